/* rtl/cprp_pkg.sv */
// ----------------------------------------------------------------------------
// cprp_pkg
// Types, constants and helper functions shared by the position record packer.
// ----------------------------------------------------------------------------
package cprp_pkg;

    localparam int SQUARES    = 64;
    localparam int CODE_SLOTS = 32;
    localparam int SLOT_W     = 5;
    localparam int KINDS      = 6;

    localparam logic signed [15:0] SCORE_MAX = 16'sd30000;
    localparam logic signed [15:0] SCORE_MIN = -16'sd30000;
    localparam logic [5:0]         KING_FLIP = 6'd56;
    localparam logic [1:0]         RESULT_WIN = 2'd2;
    localparam logic [3:0]         OPP_MARK  = 4'd8;

    typedef struct packed {
        logic [63:0]        white_pieces;
        logic [63:0]        black_pieces;
        logic [63:0]        pawn_board;
        logic [63:0]        knight_board;
        logic [63:0]        bishop_board;
        logic [63:0]        rook_board;
        logic [63:0]        queen_board;
        logic [63:0]        king_board;
        logic               black_to_move;
        logic signed [15:0] white_score;
        logic [1:0]         white_result;
    } pos_item_t;

    typedef struct packed {
        logic [63:0]        occupancy;
        logic [63:0]        codes_low;
        logic [63:0]        codes_high;
        logic signed [15:0] mover_score;
        logic [1:0]         mover_result;
        logic [5:0]         own_king_square;
        logic [5:0]         their_king_square;
        logic               too_many_pieces;
    } rec_item_t;

    // classified position, one code per square, waiting for packing
    typedef struct packed {
        logic [63:0]             occupancy;
        logic [SQUARES-1:0][3:0] codes;
        logic signed [15:0]      mover_score;
        logic [1:0]              mover_result;
        logic [5:0]              own_king_square;
        logic [5:0]              their_king_square;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // vertical mirror of a board
    function automatic logic [63:0] byte_swap(input logic [63:0] v);
        logic [63:0] r;
        for (int b = 0; b < 8; b++)
        begin
            r[8*b +: 8] = v[8*(7-b) +: 8];
        end
        return r;
    endfunction

    // lowest set square, 0 when the board is empty
    function automatic logic [5:0] lowest_square(input logic [63:0] v);
        logic [7:0] byte_nz;
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] sel_byte;
        for (int b = 0; b < 8; b++)
        begin
            byte_nz[b] = |v[8*b +: 8];
        end
        byte_sel = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (byte_nz[b])
            begin
                byte_sel = 3'(b);
            end
        end
        sel_byte = v[{byte_sel, 3'd0} +: 8];
        bit_sel = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (sel_byte[i])
            begin
                bit_sel = 3'(i);
            end
        end
        return {byte_sel, bit_sel};
    endfunction

endpackage

/* rtl/cprp_front.sv */
// ----------------------------------------------------------------------------
// cprp_front
// Turns a position to the mover's view, clamps the score and classifies
// every square into its 4-bit piece code.
// ----------------------------------------------------------------------------
module cprp_front (
    input  cprp_pkg::pos_item_t pos,
    output cprp_pkg::job_t      job
);
    import cprp_pkg::*;

    logic                    flip;
    logic [63:0]             own;
    logic [63:0]             opp;
    logic [KINDS-1:0][63:0]  kinds;
    logic [KINDS-1:0][63:0]  kinds_raw;
    logic signed [15:0]      clamped;
    logic [2:0]              kind_code;

    assign flip = pos.black_to_move;
    assign kinds_raw = {pos.king_board, pos.queen_board, pos.rook_board,
                        pos.bishop_board, pos.knight_board, pos.pawn_board};

    always_comb
    begin
        own = flip ? byte_swap(pos.black_pieces) : pos.white_pieces;
        opp = flip ? byte_swap(pos.white_pieces) : pos.black_pieces;
        for (int k = 0; k < KINDS; k++)
        begin
            kinds[k] = flip ? byte_swap(kinds_raw[k]) : kinds_raw[k];
        end

        if (pos.white_score > SCORE_MAX)
        begin
            clamped = SCORE_MAX;
        end
        else if (pos.white_score < SCORE_MIN)
        begin
            clamped = SCORE_MIN;
        end
        else
        begin
            clamped = pos.white_score;
        end

        job.occupancy    = own | opp;
        job.mover_score  = flip ? -clamped : clamped;
        job.mover_result = flip ? RESULT_WIN - pos.white_result : pos.white_result;
        job.own_king_square   = lowest_square(own & kinds[KINDS-1]);
        job.their_king_square = lowest_square(opp & kinds[KINDS-1]) ^ KING_FLIP;

        // lowest piece kind wins, none reads as pawn
        for (int sq = 0; sq < SQUARES; sq++)
        begin
            kind_code = 3'd0;
            for (int k = KINDS - 1; k >= 0; k--)
            begin
                if (kinds[k][sq])
                begin
                    kind_code = 3'(k);
                end
            end
            job.codes[sq] = (opp[sq] ? OPP_MARK : 4'd0) | {1'b0, kind_code};
        end
    end

endmodule

/* rtl/cprp_queue.sv */
// ----------------------------------------------------------------------------
// cprp_queue
// Two-entry queue of classified positions between the front and back parts.
// ----------------------------------------------------------------------------
module cprp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cprp_pkg::job_t      push_job,
    input  logic                pop,
    output cprp_pkg::job_t      head_job,
    output cprp_pkg::q_status_t status
);
    import cprp_pkg::*;

    job_t       entries [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head_job     = entries[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/cprp_back.sv */
// ----------------------------------------------------------------------------
// cprp_back
// Packs the codes of up to MAX_CODES occupied squares in ascending order, one square per
// cycle, drops the rest and holds the finished record in the output register.
// ----------------------------------------------------------------------------
module cprp_back #(
    parameter int MAX_CODES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cprp_pkg::q_status_t q_status,
    input  cprp_pkg::job_t      job,
    output logic                job_pop,
    output cprp_pkg::rec_item_t rec,
    output logic                rec_valid,
    input  logic                rec_ready
);
    import cprp_pkg::*;

    localparam int CNT_W = $clog2(MAX_CODES + 1);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t                     state_reg, state_next;
    job_t                       job_reg, job_next;
    logic [63:0]                rest_reg, rest_next;
    logic [CODE_SLOTS-1:0][3:0] acc_reg, acc_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       over_reg, over_next;
    rec_item_t                  rec_reg, rec_next;
    logic                       rec_valid_reg, rec_valid_next;

    logic [63:0] low_bit;
    logic [3:0]  pick;
    logic        at_limit;
    logic        out_free;

    assign job_pop   = (state_reg == IDLE) && !q_status.empty;
    assign rec       = rec_reg;
    assign rec_valid = rec_valid_reg;

    always_comb
    begin
        low_bit  = rest_reg & (~rest_reg + 64'd1);
        pick     = 4'd0;
        for (int i = 0; i < SQUARES; i++)
        begin
            pick = pick | ({4{low_bit[i]}} & job_reg.codes[i]);
        end
        at_limit = (count_reg == CNT_W'(MAX_CODES));
        out_free = !rec_valid_reg || rec_ready;

        state_next     = state_reg;
        job_next       = job_reg;
        rest_next      = rest_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        over_next      = over_reg;
        rec_next       = rec_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;

        case (state_reg)
            IDLE:
            begin
                if (!q_status.empty)
                begin
                    job_next   = job;
                    rest_next  = job.occupancy;
                    acc_next   = '0;
                    count_next = '0;
                    over_next  = 1'b0;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (rest_reg != 64'd0)
                begin
                    if (at_limit)
                    begin
                        // remaining squares are dropped
                        over_next = 1'b1;
                        rest_next = 64'd0;
                    end
                    else
                    begin
                        acc_next[SLOT_W'(count_reg)] = pick;
                        count_next = count_reg + CNT_W'(1);
                        rest_next  = rest_reg & (rest_reg - 64'd1);
                    end
                end
                else if (out_free)
                begin
                    rec_next.occupancy         = job_reg.occupancy;
                    rec_next.codes_low         = acc_reg[15:0];
                    rec_next.codes_high        = acc_reg[31:16];
                    rec_next.mover_score       = job_reg.mover_score;
                    rec_next.mover_result      = job_reg.mover_result;
                    rec_next.own_king_square   = job_reg.own_king_square;
                    rec_next.their_king_square = job_reg.their_king_square;
                    rec_next.too_many_pieces   = over_reg;
                    rec_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            job_reg       <= '0;
            rest_reg      <= '0;
            acc_reg       <= '0;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            rec_reg       <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            rest_reg      <= rest_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            over_reg      <= over_next;
            rec_reg       <= rec_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

endmodule

/* rtl/chess_position_record_packer.sv */
// ----------------------------------------------------------------------------
// chess_position_record_packer
// Packs one chess position into one 223-bit training record seen from the
// side to move.
//
//   channel   signals                    payload
//   position  pos_valid / pos_ready      pos (pos_item_t)
//   record    rec_valid / rec_ready      rec (rec_item_t)
//
// the front classifies a position in the cycle it is accepted and writes it
// into a two-entry queue; pos_ready is low only while the queue is full
// the packer scans the occupied squares one square per cycle, up to
// MAX_CODES, and drops the rest; it takes a new position only once the
// record is written to the output register, so its scan sets the rate
// reset clears control and packer state but not the queue entries, no clearing pass
// a stalled record holds in the output register while the next is packed
// ----------------------------------------------------------------------------
module chess_position_record_packer #(
    parameter int MAX_CODES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pos_valid,
    output logic                pos_ready,
    input  cprp_pkg::pos_item_t pos,
    output logic                rec_valid,
    input  logic                rec_ready,
    output cprp_pkg::rec_item_t rec
);
    import cprp_pkg::*;

    job_t      front_job;
    job_t      head_job;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign pos_ready = !q_status.full;
    assign push      = pos_valid && pos_ready;

    cprp_front u_front (
        .pos (pos),
        .job (front_job)
    );

    cprp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    cprp_back #(
        .MAX_CODES (MAX_CODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .job       (head_job),
        .job_pop   (pop),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready)
    );

    // overflow flag agrees with the occupancy count
    a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (($countones(rec.occupancy) > MAX_CODES) == rec.too_many_pieces))
    else $error("overflow flag does not match occupancy");

    // a found own king sits on an occupied square
    a_own_king: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec.own_king_square != 6'd0) |-> rec.occupancy[rec.own_king_square])
    else $error("own king square not occupied");

    // score stays clamped after the flip
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> (rec.mover_score <= SCORE_MAX && rec.mover_score >= SCORE_MIN))
    else $error("mover score out of range");

    // the queue is never popped while empty
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
    else $error("queue popped while empty");

endmodule
